>>> rtl/lmfs_pkg.sv
// Shared types and constants for the LED matrix framebuffer scanner.
// Holds the item structs, command codes and matrix geometry; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lmfs_pkg;

  localparam int COLUMNS = 5;
  localparam int ROWS    = 7;

  // Column address width inside the stores
  localparam int ColAw = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  localparam logic [7:0] FILL_BYTE  = 8'h7F;
  localparam logic [7:0] CLEAR_BYTE = 8'h00;

  // Rows that a scan may drive; rows at or above ROWS stay dark
  localparam logic [6:0] ROW_MASK = 7'((1 << ROWS) - 1);

  localparam logic [2:0] CMD_SET_PIXEL  = 3'd0;
  localparam logic [2:0] CMD_SET_COLUMN = 3'd1;
  localparam logic [2:0] CMD_GET_PIXEL  = 3'd2;
  localparam logic [2:0] CMD_CLEAR      = 3'd3;
  localparam logic [2:0] CMD_FILL       = 3'd4;
  localparam logic [2:0] CMD_PUSH       = 3'd5;
  localparam logic [2:0] CMD_POP        = 3'd6;
  localparam logic [2:0] CMD_SCAN       = 3'd7;

  typedef struct packed {
    logic [2:0] command;
    logic [2:0] column_index;
    logic [2:0] row_index;
    logic       pixel_on;
    logic [7:0] column_pattern;
  } in_item_t;

  typedef struct packed {
    logic       pixel_value;
    logic [6:0] row_lines;
    logic [4:0] column_lines;
  } out_item_t;

  // Command handed from the input register to the execution units
  typedef struct packed {
    logic     fire;
    in_item_t item;
  } exec_t;

endpackage

`default_nettype wire

>>> rtl/lmfs_store.sv
// Frame store and shadow store with all pixel and whole-frame commands.
// Depends on lmfs_pkg for geometry, command codes and the exec_t struct.
`timescale 1ns / 1ps
`default_nettype none

module lmfs_store (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lmfs_pkg::exec_t        exec,
  input  wire logic [lmfs_pkg::ColAw-1:0] scan_col,
  output logic                        pixel_value,
  output logic [7:0]                  scan_byte
);
  import lmfs_pkg::*;

  logic [7:0]       frame_r  [COLUMNS];
  logic [7:0]       shadow_r [COLUMNS];
  logic             col_ok;
  logic             row_ok;
  logic [ColAw-1:0] col_a;

  assign col_ok = (32'(exec.item.column_index) < COLUMNS);
  assign row_ok = (32'(exec.item.row_index) < ROWS);
  assign col_a  = exec.item.column_index[ColAw-1:0];

  always_comb begin
    pixel_value = 1'b0;
    if (exec.item.command == CMD_GET_PIXEL && col_ok && row_ok) begin
      pixel_value = frame_r[col_a][exec.item.row_index];
    end
  end

  assign scan_byte = frame_r[scan_col];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COLUMNS; i++) begin
        frame_r[i]  <= CLEAR_BYTE;
        shadow_r[i] <= CLEAR_BYTE;
      end
    end else if (exec.fire) begin
      unique case (exec.item.command)
        CMD_SET_PIXEL: begin
          if (col_ok && row_ok) begin
            frame_r[col_a][exec.item.row_index] <= exec.item.pixel_on;
          end
        end
        CMD_SET_COLUMN: begin
          if (col_ok) begin
            frame_r[col_a] <= exec.item.column_pattern;
          end
        end
        CMD_CLEAR: begin
          for (int i = 0; i < COLUMNS; i++) frame_r[i] <= CLEAR_BYTE;
        end
        CMD_FILL: begin
          for (int i = 0; i < COLUMNS; i++) frame_r[i] <= FILL_BYTE;
        end
        CMD_PUSH: begin
          for (int i = 0; i < COLUMNS; i++) shadow_r[i] <= frame_r[i];
        end
        CMD_POP: begin
          for (int i = 0; i < COLUMNS; i++) frame_r[i] <= shadow_r[i];
        end
        default: begin
          // get pixel and scan tick leave the stores alone
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/lmfs_scan.sv
// Column scan sequencer and active-low row/column drive registers.
// Depends on lmfs_pkg; reads the scanned column byte from lmfs_store.
`timescale 1ns / 1ps
`default_nettype none

module lmfs_scan (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire lmfs_pkg::exec_t            exec,
  input  wire logic [7:0]                 scan_byte,
  output logic [lmfs_pkg::ColAw-1:0]      scan_col,
  output logic [6:0]                      row_drive_nxt,
  output logic [4:0]                      column_drive_nxt
);
  import lmfs_pkg::*;

  logic [ColAw-1:0] scan_col_r;
  logic [ColAw-1:0] scan_col_nxt;
  logic [6:0]       row_drive_r;
  logic [4:0]       column_drive_r;
  logic             tick;

  assign scan_col = scan_col_r;
  assign tick     = exec.fire && (exec.item.command == CMD_SCAN);

  always_comb begin
    scan_col_nxt     = scan_col_r;
    row_drive_nxt    = row_drive_r;
    column_drive_nxt = column_drive_r;
    if (tick) begin
      row_drive_nxt    = ~(scan_byte[6:0] & ROW_MASK);
      // a column beyond the five lines shifts out and leaves all lines high
      column_drive_nxt = ~(5'd1 << scan_col_r);
      scan_col_nxt     = (scan_col_r == ColAw'(COLUMNS - 1)) ? '0 : scan_col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_col_r     <= '0;
      row_drive_r    <= '1;
      column_drive_r <= '1;
    end else begin
      scan_col_r     <= scan_col_nxt;
      row_drive_r    <= row_drive_nxt;
      column_drive_r <= column_drive_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/led_matrix_framebuffer_scanner.sv
// LED matrix framebuffer scanner: 5x7 column-multiplexed dot-matrix driver.
// Path: an accepted item waits in the input register, then its result is written to the result register.
// Throughput: one item per cycle while out_stall does not hold the result; each item is a single pass through the
//   store and scan logic between the input register and the result register.
// Reset (rst_n low, synchronous): both stores cleared, scan column at zero,
//   all row and column drive lines high, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module led_matrix_framebuffer_scanner (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lmfs_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lmfs_pkg::out_item_t      out_item
);
  import lmfs_pkg::*;

  logic       s1_valid_r;
  in_item_t   s1_item_r;
  logic       out_valid_r;
  out_item_t  out_item_r;
  logic       advance;
  exec_t      exec;
  logic       pixel_value;
  logic [7:0] scan_byte;
  logic [ColAw-1:0] scan_col;
  logic [6:0] row_drive_nxt;
  logic [4:0] column_drive_nxt;

  // Advance the whole pipe whenever the result slot is free or being taken
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;

  // An item in the input register executes in the cycle it moves to the output
  assign exec = {advance && s1_valid_r, s1_item_r};

  lmfs_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .exec        (exec),
    .scan_col    (scan_col),
    .pixel_value (pixel_value),
    .scan_byte   (scan_byte)
  );

  lmfs_scan u_scan (
    .clk              (clk),
    .rst_n            (rst_n),
    .exec             (exec),
    .scan_byte        (scan_byte),
    .scan_col         (scan_col),
    .row_drive_nxt    (row_drive_nxt),
    .column_drive_nxt (column_drive_nxt)
  );

  // Control: valid bits of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  // Payload: hold while stalled, no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item_r               <= in_item;
      out_item_r.pixel_value  <= pixel_value;
      out_item_r.row_lines    <= row_drive_nxt;
      out_item_r.column_lines <= column_drive_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

>>> verif/tb.sv
// Self-checking bench for the LED matrix framebuffer scanner: directed rows, then random commands.
// Carries its own model of the frame, shadow and scan drive; depends only on lmfs_pkg and the DUT.
`timescale 1ns / 1ps

module tb;
  import lmfs_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int DIRECTED_ROWS = 25;
  localparam logic [7:0] LIT_ROWS = 8'((1 << ROWS) - 1);

  // One command queued for the sender. Rows with 'typed' set carry the
  // display state written out by hand; all others use the model's answer.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } cmd_entry_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  led_matrix_framebuffer_scanner dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Model of the matrix: frame, shadow copy, next column and drive lines
  logic [7:0]  frame_m  [COLUMNS];
  logic [7:0]  shadow_m [COLUMNS];
  int unsigned next_col;
  logic [6:0]  rows_m;
  logic [4:0]  cols_m;

  cmd_entry_t  send_q[$];
  cmd_entry_t  cur_entry = '0;
  cmd_entry_t  nxt;
  out_item_t   display_due[$];
  out_item_t   want;
  int          fails = 0;
  int          gap_left = 0;
  int          burst_left = 0;
  logic [31:0] stall_phase = '0;
  stall_mode_t stall_mode = STALL_NONE;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up well past the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Apply one command to the model and return the display state it leaves
  function automatic out_item_t apply_command(in_item_t it);
    out_item_t  r;
    logic       pix;
    logic [7:0] bitm;
    int unsigned c;
    pix = 1'b0;
    bitm = 8'd1 << it.row_index;
    case (it.command)
      CMD_SET_PIXEL: begin
        if (it.column_index < COLUMNS && it.row_index < ROWS) begin
          frame_m[it.column_index] = (frame_m[it.column_index] & ~bitm) |
                                     (it.pixel_on ? bitm : 8'h00);
        end
      end
      CMD_SET_COLUMN: begin
        if (it.column_index < COLUMNS) frame_m[it.column_index] = it.column_pattern;
      end
      CMD_GET_PIXEL: begin
        if (it.column_index < COLUMNS && it.row_index < ROWS) begin
          pix = frame_m[it.column_index][it.row_index];
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < COLUMNS; i++) frame_m[i] = 8'h00;
      end
      CMD_FILL: begin
        for (int i = 0; i < COLUMNS; i++) frame_m[i] = 8'h7F;
      end
      CMD_PUSH: begin
        for (int i = 0; i < COLUMNS; i++) shadow_m[i] = frame_m[i];
      end
      CMD_POP: begin
        for (int i = 0; i < COLUMNS; i++) frame_m[i] = shadow_m[i];
      end
      default: begin
        // Scan tick: light the current column, then advance with wrap
        c = (next_col >= COLUMNS) ? 0 : next_col;
        rows_m = 7'(~(frame_m[c] & LIT_ROWS));
        cols_m = 5'(~(32'd1 << c));
        next_col = (c + 1 >= COLUMNS) ? 0 : c + 1;
      end
    endcase
    r.pixel_value  = pix;
    r.row_lines    = rows_m;
    r.column_lines = cols_m;
    return r;
  endfunction

  function automatic cmd_entry_t entry(logic [2:0] cmd, logic [2:0] col, logic [2:0] row,
                                       logic on, logic [7:0] pat, logic typed,
                                       logic pix, logic [6:0] rows, logic [4:0] cols);
    cmd_entry_t e;
    e.item.command        = cmd;
    e.item.column_index   = col;
    e.item.row_index      = row;
    e.item.pixel_on       = on;
    e.item.column_pattern = pat;
    e.typed               = typed;
    e.want.pixel_value    = pix;
    e.want.row_lines      = rows;
    e.want.column_lines   = cols;
    return e;
  endfunction

  // Sender: bursts of random length, random gaps between them.
  // Hold the item while stalled; load the next one once it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (send_q.size() != 0) begin
        nxt = send_q.pop_front();
        cur_entry <= nxt;
        in_item   <= nxt.item;
        in_valid  <= 1'b1;
        if (burst_left > 0) burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(24, 1);
          // Skip the gap now and then so back-to-back stretches occur
          gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall style is redrawn at random whenever stall_phase[6:0] wraps to zero
  always @(posedge clk) begin
    stall_phase = stall_phase + 1;
    if (stall_phase[6:0] == 7'd0) stall_mode = stall_mode_t'($urandom_range(3));
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(1) == 0);
      default:     out_stall <= (stall_phase[3:0] < 4'd5);
    endcase
  end

  // Check results against the oldest expectation, then record new items
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < COLUMNS; i++) begin
        frame_m[i]  = 8'h00;
        shadow_m[i] = 8'h00;
      end
      next_col = 0;
      rows_m   = 7'h7F;
      cols_m   = 5'h1F;
    end else begin
      if (out_valid && !out_stall) begin
        if (display_due.size() == 0) begin
          $error("result with no item pending");
          fails++;
        end else begin
          want = display_due.pop_front();
          if (out_item.pixel_value !== want.pixel_value) begin
            $error("pixel_value: expected %0d, actual %0d", want.pixel_value,
                   out_item.pixel_value);
            fails++;
          end
          if (out_item.row_lines !== want.row_lines) begin
            $error("row_lines: expected %h, actual %h", want.row_lines, out_item.row_lines);
            fails++;
          end
          if (out_item.column_lines !== want.column_lines) begin
            $error("column_lines: expected %h, actual %h", want.column_lines,
                   out_item.column_lines);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = apply_command(cur_entry.item);
        display_due.push_back(cur_entry.typed ? cur_entry.want : want);
      end
    end
  end

  initial begin
    cmd_entry_t  directed_tab [DIRECTED_ROWS];
    cmd_entry_t  e;
    int          pick;
    int          drain;

    // Directed rows: command, column, row, on, pattern, typed, pixel, rows, columns
    directed_tab[0]  = entry(CMD_GET_PIXEL,  0, 0, 0, 8'h00, 1, 0, 7'h7F, 5'h1F);
    // Scan with every unused field at its top value
    directed_tab[1]  = entry(CMD_SCAN,       7, 7, 1, 8'hFF, 1, 0, 7'h7F, 5'h1E);
    directed_tab[2]  = entry(CMD_FILL,       0, 0, 0, 8'h00, 1, 0, 7'h7F, 5'h1E);
    directed_tab[3]  = entry(CMD_SCAN,       0, 0, 0, 8'h00, 1, 0, 7'h00, 5'h1D);
    directed_tab[4]  = entry(CMD_GET_PIXEL,  4, 6, 0, 8'h00, 1, 1, 7'h00, 5'h1D);
    // Out-of-range column and row reads return 0
    directed_tab[5]  = entry(CMD_GET_PIXEL,  5, 0, 0, 8'h00, 1, 0, 7'h00, 5'h1D);
    directed_tab[6]  = entry(CMD_SET_COLUMN, 0, 0, 0, 8'hFF, 0, 0, 7'h00, 5'h00);
    directed_tab[7]  = entry(CMD_GET_PIXEL,  0, 7, 0, 8'h00, 1, 0, 7'h00, 5'h1D);
    directed_tab[8]  = entry(CMD_GET_PIXEL,  7, 7, 1, 8'hFF, 1, 0, 7'h00, 5'h1D);
    // Out-of-range writes must leave the frame alone; row 12 is an in-range write that clears pixel (3,0)
    directed_tab[9]  = entry(CMD_SET_COLUMN, 7, 0, 0, 8'h55, 0, 0, 7'h00, 5'h00);
    directed_tab[10] = entry(CMD_SET_PIXEL,  6, 0, 1, 8'h00, 0, 0, 7'h00, 5'h00);
    directed_tab[11] = entry(CMD_SET_PIXEL,  2, 7, 1, 8'h00, 0, 0, 7'h00, 5'h00);
    directed_tab[12] = entry(CMD_SET_PIXEL,  3, 0, 0, 8'hFF, 0, 0, 7'h00, 5'h00);
    directed_tab[13] = entry(CMD_PUSH,       0, 0, 0, 8'h00, 0, 0, 7'h00, 5'h00);
    directed_tab[14] = entry(CMD_CLEAR,      0, 0, 0, 8'h00, 0, 0, 7'h00, 5'h00);
    directed_tab[15] = entry(CMD_GET_PIXEL,  4, 6, 0, 8'h00, 1, 0, 7'h00, 5'h1D);
    directed_tab[16] = entry(CMD_SCAN,       0, 0, 0, 8'h00, 1, 0, 7'h7F, 5'h1B);
    directed_tab[17] = entry(CMD_POP,        0, 0, 0, 8'h00, 0, 0, 7'h00, 5'h00);
    directed_tab[18] = entry(CMD_SCAN,       0, 0, 0, 8'h00, 1, 0, 7'h01, 5'h17);
    directed_tab[19] = entry(CMD_SCAN,       0, 0, 0, 8'h00, 1, 0, 7'h00, 5'h0F);
    // Wrap back to column 0; bit 7 of its byte must not show
    directed_tab[20] = entry(CMD_SCAN,       0, 0, 0, 8'h00, 1, 0, 7'h00, 5'h1E);
    directed_tab[21] = entry(CMD_SET_COLUMN, 1, 0, 0, 8'h80, 0, 0, 7'h00, 5'h00);
    directed_tab[22] = entry(CMD_SCAN,       0, 0, 0, 8'h00, 1, 0, 7'h7F, 5'h1D);
    directed_tab[23] = entry(CMD_SET_PIXEL,  1, 0, 1, 8'hFF, 0, 0, 7'h00, 5'h00);
    directed_tab[24] = entry(CMD_GET_PIXEL,  1, 0, 1, 8'hFF, 0, 0, 7'h00, 5'h00);
    for (int n = 0; n < DIRECTED_ROWS; n++) send_q.push_back(directed_tab[n]);

    // Random commands: scans and reads dominate so the frame is observed often;
    // addresses mostly in range, the rest drawn from the full 3-bit field
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      e = '0;
      pick = $urandom_range(99);
      if (pick < 22)      e.item.command = CMD_SCAN;
      else if (pick < 44) e.item.command = CMD_GET_PIXEL;
      else if (pick < 62) e.item.command = CMD_SET_PIXEL;
      else if (pick < 76) e.item.command = CMD_SET_COLUMN;
      else if (pick < 82) e.item.command = CMD_CLEAR;
      else if (pick < 88) e.item.command = CMD_FILL;
      else if (pick < 94) e.item.command = CMD_PUSH;
      else                e.item.command = CMD_POP;
      e.item.column_index = 3'(($urandom_range(9) < 8) ? $urandom_range(COLUMNS - 1)
                                                       : $urandom_range(7));
      e.item.row_index    = 3'(($urandom_range(9) < 8) ? $urandom_range(ROWS - 1)
                                                       : $urandom_range(7));
      e.item.pixel_on       = 1'($urandom_range(1));
      e.item.column_pattern = 8'($urandom_range(255));
      send_q.push_back(e);
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all items taken, all results back, then a short quiet spell
    do @(negedge clk); while (send_q.size() != 0 || in_valid);
    drain = 0;
    while (display_due.size() != 0 && drain < 1000) begin
      @(negedge clk);
      drain++;
    end
    repeat (10) @(negedge clk);
    if (display_due.size() != 0) begin
      $error("%0d results never arrived", display_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> led_matrix_framebuffer_scanner.f
rtl/lmfs_pkg.sv
rtl/lmfs_store.sv
rtl/lmfs_scan.sv
rtl/led_matrix_framebuffer_scanner.sv
verif/tb.sv
